// ===== src/aes128_ecb_encrypt_macros.svh =====
// Assertion macros shared by the AES-128 checker.
// Plain text macros only; no dependencies.
`ifndef AES128_ECB_ENCRYPT_MACROS_SVH
`define AES128_ECB_ENCRYPT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define AES_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/aes_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the AES-128 encryptor.
// No dependencies; used by every module of the block.
`default_nettype none

package aes_pkg;

   // Block state: byte 0 is element 0 and sits in the most significant bits
   typedef logic [0:15][7:0] block_type;

   // Beat payloads
   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
      logic        final_block;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        final_out;
   } rsp_payload_type;

   // Rounds
   localparam int ROUNDS      = 10;
   localparam int ROUND_WIDTH = $clog2(ROUNDS);
   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND = ROUND_WIDTH'(ROUNDS - 1);

   // CSR map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic                   load;     // take a new block, apply initial key add
      logic                   step;     // run one full round into the state register
      logic                   capture;  // run the final round into the output register
      logic [ROUND_WIDTH-1:0] round_idx;
   } dp_cmd_type;

   // Forward S-box
   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      return SBOX_TABLE[x];
   endfunction

   // Multiply by two in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Round constant for key expansion step idx
   function automatic logic [7:0] rcon(input logic [ROUND_WIDTH-1:0] idx);
      logic [7:0] r;
      unique case (idx)
         4'd0:    r = 8'h01;
         4'd1:    r = 8'h02;
         4'd2:    r = 8'h04;
         4'd3:    r = 8'h08;
         4'd4:    r = 8'h10;
         4'd5:    r = 8'h20;
         4'd6:    r = 8'h40;
         4'd7:    r = 8'h80;
         4'd8:    r = 8'h1b;
         4'd9:    r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/aes_ctrl.sv =====
// Sequencer for the AES-128 encryptor: accepts beats, counts rounds,
// owns the result valid flag. Uses aes_pkg.
`default_nettype none

module aes_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output aes_pkg::dp_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [aes_pkg::ROUND_WIDTH-1:0]    round_ff, round_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               out_free;

   // Output register can take a result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.capture   = 1'b0;
      cmd.round_idx = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (round_ff != aes_pkg::LAST_ROUND) begin
               cmd.step = 1'b1;
               round_in = round_ff + aes_pkg::ROUND_WIDTH'(1);
            end else if (out_free) begin
               // final round goes straight to the output register
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on capture, cleared when the beat is taken
   always_comb begin
      priority if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/aes_datapath.sv =====
// Round unit of the AES-128 encryptor: key registers, state and round key
// registers, one round with on-the-fly key expansion, output register. Uses aes_pkg.
`default_nettype none

module aes_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire aes_pkg::dp_cmd_type                     cmd,
   input  wire aes_pkg::req_payload_type                req_data,
   input  wire logic                                    csr_valid,
   input  wire logic [aes_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [63:0]                             csr_wdata,
   output aes_pkg::rsp_payload_type                     rsp_data
);

   logic [63:0]               key_high_ff, key_low_ff;
   aes_pkg::block_type        key_block;
   aes_pkg::block_type        state_ff, state_in;
   aes_pkg::block_type        rkey_ff, rkey_in;
   logic                      final_ff, final_in;
   aes_pkg::rsp_payload_type  out_ff;

   aes_pkg::block_type        sub_shifted;
   aes_pkg::block_type        mixed;
   aes_pkg::block_type        next_key;
   aes_pkg::block_type        round_out;
   aes_pkg::block_type        final_out;
   logic [7:0]                a0, a1, a2, a3;
   logic [7:0]                t0, t1, t2, t3;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         priority if (csr_index == aes_pkg::CSR_KEY_HIGH) begin
            key_high_ff <= csr_wdata;
         end else if (csr_index == aes_pkg::CSR_KEY_LOW) begin
            key_low_ff <= csr_wdata;
         end
      end
   end

   assign key_block = {key_high_ff, key_low_ff};

   // SubBytes with ShiftRows: row r rotates left by r columns
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sub_shifted[4*c + r] = aes_pkg::sub_byte(state_ff[4*((c + r) % 4) + r]);
         end
      end
   end

   // MixColumns
   always_comb begin
      mixed = sub_shifted;
      a0 = '0; a1 = '0; a2 = '0; a3 = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = sub_shifted[4*c];
         a1 = sub_shifted[4*c + 1];
         a2 = sub_shifted[4*c + 2];
         a3 = sub_shifted[4*c + 3];
         mixed[4*c]     = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
         mixed[4*c + 1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
         mixed[4*c + 2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
         mixed[4*c + 3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
      end
   end

   // Key expansion: next round key from the current one
   always_comb begin
      t0 = aes_pkg::sub_byte(rkey_ff[13]) ^ aes_pkg::rcon(cmd.round_idx);
      t1 = aes_pkg::sub_byte(rkey_ff[14]);
      t2 = aes_pkg::sub_byte(rkey_ff[15]);
      t3 = aes_pkg::sub_byte(rkey_ff[12]);
      next_key[0] = rkey_ff[0] ^ t0;
      next_key[1] = rkey_ff[1] ^ t1;
      next_key[2] = rkey_ff[2] ^ t2;
      next_key[3] = rkey_ff[3] ^ t3;
      for (int j = 4; j < 16; j++) begin
         next_key[j] = rkey_ff[j] ^ next_key[j-4];
      end
   end

   // AddRoundKey for full and final rounds
   assign round_out = mixed ^ next_key;
   assign final_out = sub_shifted ^ next_key;

   // State, round key and mark
   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      final_in = final_ff;
      if (cmd.load) begin
         state_in = aes_pkg::block_type'({req_data.plain_high, req_data.plain_low}) ^ key_block;
         rkey_in  = key_block;
         final_in = req_data.final_block;
      end else if (cmd.step) begin
         state_in = round_out;
         rkey_in  = next_key;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      final_ff <= final_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         out_ff.cipher_high <= final_out[0:7];
         out_ff.cipher_low  <= final_out[8:15];
         out_ff.final_out   <= final_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

// ===== src/aes128_ecb_encrypt.sv =====
// Top level of the AES-128 ECB encryptor: sequencer plus round datapath.
// Depends on aes_pkg, aes_ctrl and aes_datapath.
//
// Encrypts one 128-bit block per request beat under the key held in the
// key_high (index 0) and key_low (index 1) CSRs; byte 0 is the most
// significant byte of each high word. The accept cycle loads the state with
// the initial key add, then a single round unit runs one round per cycle,
// except while held as described below, for ten rounds, expanding the round
// key alongside it. The next block is accepted in the cycle after the final
// round, so only one block is in the round unit at a time. The result waits
// in an output register while the next block is encrypted; if it is still
// not taken when that block's final round is due, the round unit holds.
// csr_ready is always high; write the key only while no block is in flight.
`default_nettype none

module aes128_ecb_encrypt (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire aes_pkg::req_payload_type             req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output aes_pkg::rsp_payload_type                  rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [aes_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [63:0]                          csr_wdata
);

   aes_pkg::dp_cmd_type cmd;

   // CSR writes never wait
   assign csr_ready = 1'b1;

   aes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   aes_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/aes_checker.sv =====
// Port-level checks for the AES-128 encryptor, bound to the top level.
// Depends on aes_pkg and aes128_ecb_encrypt_macros.svh.
`default_nettype none
`include "aes128_ecb_encrypt_macros.svh"

module aes_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire aes_pkg::rsp_payload_type  rsp_data
);

   // A stalled result beat holds
   `AES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // An accepted block keeps the input busy
   `AES_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input not stalled after accept")

   // Ten rounds: busy never lasts a single cycle
   `AES_ASSERT_NEXT(a_busy_min, clock, reset, $rose(req_stall), req_stall, "busy period too short")

   // A new result only appears at the end of a busy period
   `AES_ASSERT_SAME(a_rsp_from_run, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a block in flight")

endmodule

bind aes128_ecb_encrypt aes_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/aes128_cipher_checker.sv =====
// Checker for the AES-128 ECB encryptor: watches the request, response and CSR beats,
// predicts each ciphertext from its own AES-128 model and compares it field by field.
// Depends on aes_pkg for the beat payload types and the CSR map.
module aes128_cipher_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  aes_pkg::req_payload_type            req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  aes_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [aes_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                         csr_wdata,
   input  logic                                end_of_test,
   output int unsigned                         fail_count,
   output int unsigned                         pending_count
);
   import aes_pkg::*;

   logic [7:0]      sbox_lut [0:255];
   logic [63:0]     key_high_shadow;
   logic [63:0]     key_low_shadow;
   rsp_payload_type pending_ciphertexts [$];
   logic            leftovers_checked;

   // GF(2^8) arithmetic, modulus x^8 + x^4 + x^3 + x + 1
   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] prod;
      prod = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i])
            prod ^= a;
         a = gf_double(a);
      end
      return prod;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
      logic [15:0] w;
      w = {b, b} << n;
      return w[15:8];
   endfunction

   // S-box entry built from scratch: multiplicative inverse (x^254), then affine map
   function automatic logic [7:0] sbox_entry(input logic [7:0] x);
      logic [7:0] sq;
      logic [7:0] inv;
      sq  = x;
      inv = 8'h01;
      for (int i = 1; i < 8; i++) begin
         sq  = gf_mul(sq, sq);
         inv = gf_mul(inv, sq);
      end
      return inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
   endfunction

   initial begin
      fail_count        = 0;
      leftovers_checked = 1'b0;
      for (int x = 0; x < 256; x++)
         sbox_lut[x] = sbox_entry(8'(x));
   end

   // Full AES-128 encryption of one block under the shadowed key
   function automatic rsp_payload_type encrypt_block(input req_payload_type blk);
      logic [7:0]      st [16];
      logic [7:0]      rk [16];
      logic [7:0]      sh [16];
      logic [7:0]      rc;
      logic [7:0]      a0, a1, a2, a3;
      rsp_payload_type res;
      rc = 8'h01;
      for (int j = 0; j < 8; j++) begin
         st[j]     = blk.plain_high[63-8*j -: 8];
         st[j + 8] = blk.plain_low[63-8*j -: 8];
         rk[j]     = key_high_shadow[63-8*j -: 8];
         rk[j + 8] = key_low_shadow[63-8*j -: 8];
      end
      for (int j = 0; j < 16; j++)
         st[j] ^= rk[j];
      for (int rnd = 0; rnd < ROUNDS; rnd++) begin
         // SubBytes and ShiftRows: row r rotates left by r columns
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               sh[4*c + r] = sbox_lut[st[4*((c + r) % 4) + r]];
         // MixColumns on all but the last round
         if (rnd < ROUNDS - 1) begin
            for (int c = 0; c < 4; c++) begin
               a0 = sh[4*c];
               a1 = sh[4*c + 1];
               a2 = sh[4*c + 2];
               a3 = sh[4*c + 3];
               st[4*c]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
               st[4*c + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
               st[4*c + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
               st[4*c + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
         end else begin
            st = sh;
         end
         // next round key: RotWord, SubWord, round constant, then the chain of xors
         rk[0] ^= sbox_lut[rk[13]] ^ rc;
         rk[1] ^= sbox_lut[rk[14]];
         rk[2] ^= sbox_lut[rk[15]];
         rk[3] ^= sbox_lut[rk[12]];
         for (int j = 4; j < 16; j++)
            rk[j] ^= rk[j - 4];
         rc = gf_double(rc);
         for (int j = 0; j < 16; j++)
            st[j] ^= rk[j];
      end
      for (int j = 0; j < 8; j++) begin
         res.cipher_high[63-8*j -: 8] = st[j];
         res.cipher_low[63-8*j -: 8]  = st[j + 8];
      end
      res.final_out = blk.final_block;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // Beat monitor: response compare first, then prediction, then key shadow
   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         key_high_shadow <= '0;
         key_low_shadow  <= '0;
         pending_ciphertexts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ciphertexts.size() == 0) begin
               report_mismatch("response beat with no block in flight",
                               rsp_data.cipher_high, '0);
            end else begin
               want = pending_ciphertexts.pop_front();
               if (rsp_data.cipher_high !== want.cipher_high)
                  report_mismatch("cipher_high", rsp_data.cipher_high, want.cipher_high);
               if (rsp_data.cipher_low !== want.cipher_low)
                  report_mismatch("cipher_low", rsp_data.cipher_low, want.cipher_low);
               if (rsp_data.final_out !== want.final_out)
                  report_mismatch("final_out", 64'(rsp_data.final_out), 64'(want.final_out));
            end
         end
         if (req_valid && !req_stall)
            pending_ciphertexts.push_back(encrypt_block(req_data));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEY_HIGH)
               key_high_shadow <= csr_wdata;
            else if (csr_index == CSR_KEY_LOW)
               key_low_shadow <= csr_wdata;
         end
         // blocks still owed a response when the test ends
         if (end_of_test && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (pending_ciphertexts.size() != 0)
               report_mismatch("blocks never answered", 64'(pending_ciphertexts.size()), '0);
         end
      end
      pending_count <= pending_ciphertexts.size();
   end

endmodule

// ===== tb/sv/aes128_ecb_encrypt_test.sv =====
// Top of the AES-128 ECB encryptor test: clock, reset, request/CSR stimulus and verdict.
// Depends on aes_pkg, aes128_ecb_encrypt and aes128_cipher_checker.
module aes128_ecb_encrypt_test;
   import aes_pkg::*;

   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int BLOCKS_PER_PHASE = 220;
   localparam int SETTLE_CYCLES    = 24;
   localparam int HOLD_OFF_CYCLES  = 400;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_payload_type            req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_payload_type            rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [63:0]                csr_wdata;
   logic                       end_of_test;
   int unsigned                fail_count;
   int unsigned                pending_count;
   int                         send_idle_pct;
   int                         rsp_stall_pct;
   int                         hold_left;
   int                         idle_cycles;

   aes128_ecb_encrypt dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   aes128_cipher_checker cipher_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .end_of_test   (end_of_test),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: too many cycles in a row without any beat ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: long hold-off when asked, otherwise random stall
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   function automatic req_payload_type make_block(input logic [63:0] hi, input logic [63:0] lo,
                                                  input logic fin);
      req_payload_type blk;
      blk.plain_high  = hi;
      blk.plain_low   = lo;
      blk.final_block = fin;
      return blk;
   endfunction

   // Mostly dense random text, with some all-zero, all-one and one-hot halves
   function automatic req_payload_type rand_block();
      req_payload_type blk;
      blk.plain_high  = {$urandom, $urandom};
      blk.plain_low   = {$urandom, $urandom};
      blk.final_block = 1'($urandom_range(1));
      case ($urandom_range(9))
         0: blk.plain_high = '0;
         1: blk.plain_low = '1;
         2: blk.plain_high = 64'(1) << $urandom_range(63);
         3: blk.plain_low = 64'(1) << $urandom_range(63);
         default: ;
      endcase
      return blk;
   endfunction

   // All stimulus tasks are entered and left just after a falling edge
   task automatic write_key_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      write_key_reg(CSR_KEY_HIGH, hi);
      write_key_reg(CSR_KEY_LOW, lo);
   endtask

   // One request beat; valid stays up across back-to-back blocks
   task automatic send_block(input req_payload_type blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = blk;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Let every block in flight come out before touching the key
   task automatic wait_drained();
      req_valid = 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int send_pct [4];
      int stall_pct [4];
      send_pct  = '{0, 50, 0, 28};
      stall_pct = '{0, 0, 50, 28};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_KEY_HIGH;
      csr_wdata     = '0;
      end_of_test   = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left     = 0;
      idle_cycles   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // key never written: all-zero reset key
      send_block(make_block('0, '0, 1'b0));
      send_block(make_block('1, '1, 1'b1));
      send_block(make_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0));
      wait_drained();

      // standard test key, extremes and single-bit texts
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(make_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0));
      send_block(make_block('0, '0, 1'b1));
      send_block(make_block('1, '1, 1'b0));
      send_block(make_block({4{16'h5555}}, {4{16'haaaa}}, 1'b1));
      send_block(make_block({4{16'haaaa}}, {4{16'h5555}}, 1'b0));
      send_block(make_block(64'h8000000000000000, '0, 1'b0));
      send_block(make_block('0, 64'h0000000000000001, 1'b1));
      wait_drained();

      // all-ones key, then a split key
      load_key('1, '1);
      send_block(make_block('0, '0, 1'b0));
      send_block(make_block('1, '1, 1'b1));
      send_block(make_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0));
      wait_drained();
      load_key('0, '1);
      send_block(make_block('0, '0, 1'b1));
      send_block(make_block('1, '0, 1'b0));
      wait_drained();

      // random phases with different idle and stall mixes and key settings
      for (int p = 0; p < 4; p++) begin
         case (p)
            1:       load_key('1, '1);
            2:       load_key('0, '0);
            default: load_key({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         send_idle_pct = send_pct[p];
         rsp_stall_pct = stall_pct[p];
         for (int i = 0; i < BLOCKS_PER_PHASE; i++) begin
            // receiver holds off while the sender keeps pushing blocks
            if (p == 0 && i == 40)
               hold_left = HOLD_OFF_CYCLES;
            send_block(rand_block());
         end
         wait_drained();
      end

      end_of_test = 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/aes_pkg.sv
src/aes_ctrl.sv
src/aes_datapath.sv
src/aes128_ecb_encrypt.sv
src/aes_checker.sv
tb/sv/aes128_cipher_checker.sv
tb/sv/aes128_ecb_encrypt_test.sv
